/* hdl/canonical_kmer_roller_defines.svh */
// ----------------------------------------------------------------------------
// Canonical k-mer roller assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CANONICAL_KMER_ROLLER_DEFINES_SVH
`define CANONICAL_KMER_ROLLER_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define KMR_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold at the same edge as the antecedent.
`define KMR_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* hdl/kmr_pkg.sv */
// ----------------------------------------------------------------------------
// Canonical k-mer roller package
// Widths, register map, reset values and shared types of the roller.
// ----------------------------------------------------------------------------
`default_nettype none

package kmr_pkg;

    localparam int MAX_K_DEF  = 64;
    localparam int SYM_W      = 3;
    localparam int LEN_W      = 7;
    localparam int WORD_W     = 64;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [LEN_W-1:0] KMER_LEN_RST = 7'd31;
    localparam logic             KMER_LEN_IDX = 1'b0;

    typedef struct packed {
        logic [LEN_W-1:0] kmer_len;
        logic             clear;
    } kmr_cfg_t;

    typedef struct packed {
        logic              kmer_ready;
        logic              fwd_canonical;
        logic              prev_fwd_canonical;
        logic              prev_kmer_existed;
        logic [LEN_W-1:0]  fill_count;
        logic [1:0]        pushed_off;
        logic [WORD_W-1:0] canon_high;
        logic [WORD_W-1:0] canon_low;
        logic              bad_symbol;
    } kmr_result_t;

    // Clamps the programmed length to 1..lim.
    function automatic logic [LEN_W-1:0] kmr_eff_len(input logic [LEN_W-1:0] len,
                                                     input logic [LEN_W-1:0] lim);
        logic [LEN_W-1:0] k;
        if (len == '0)
        begin
            k = 7'd1;
        end
        else if (len > lim)
        begin
            k = lim;
        end
        else
        begin
            k = len;
        end
        return k;
    endfunction

endpackage

`default_nettype wire

/* hdl/kmr_sym_if.sv */
// ----------------------------------------------------------------------------
// Nucleotide input channel
// Valid/ready channel that carries one 3-bit symbol per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface kmr_sym_if;
    logic                        valid;
    logic                        ready;
    logic [kmr_pkg::SYM_W-1:0]   symbol;

    modport source (output valid, output symbol, input ready);
    modport sink   (input valid, input symbol, output ready);
endinterface

`default_nettype wire

/* hdl/kmr_res_if.sv */
// ----------------------------------------------------------------------------
// Canonical k-mer result channel
// Valid/ready channel that carries one canonical k-mer result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface kmr_res_if;
    logic                         valid;
    logic                         ready;
    logic                         kmer_ready;
    logic                         fwd_canonical;
    logic                         prev_fwd_canonical;
    logic                         prev_kmer_existed;
    logic [kmr_pkg::LEN_W-1:0]    fill_count;
    logic [1:0]                   pushed_off;
    logic [kmr_pkg::WORD_W-1:0]   canon_high;
    logic [kmr_pkg::WORD_W-1:0]   canon_low;
    logic                         bad_symbol;

    modport source (output valid, output kmer_ready, output fwd_canonical,
                    output prev_fwd_canonical, output prev_kmer_existed,
                    output fill_count, output pushed_off, output canon_high,
                    output canon_low, output bad_symbol, input ready);
    modport sink   (input valid, input kmer_ready, input fwd_canonical,
                    input prev_fwd_canonical, input prev_kmer_existed,
                    input fill_count, input pushed_off, input canon_high,
                    input canon_low, input bad_symbol, output ready);
endinterface

`default_nettype wire

/* hdl/canonical_kmer_roller.sv */
// ----------------------------------------------------------------------------
// Canonical k-mer roller
// Rolling canonical k-mer over a stream of 2-bit nucleotide codes.
// ----------------------------------------------------------------------------
// Symbols arrive on sym_in, one 3-bit code per beat; codes 4 to 7 are
// invalid, clear the windows and produce a result marked bad_symbol.
// Each beat yields exactly one beat on res_out with the canonical k-mer,
// its flags, the fill count and the character that left the window.
// The k-mer length is set through the APB register at address 0 (only
// paddr[2] is decoded); a write clears the windows, counters and flags.
// Writes are to be made only while idle; the block does not enforce this.
// A symbol is held in an input register, then the window update and the
// 128-bit compare run combinationally into the result register, which
// offers it on res_out. While the receiver does not stall, one symbol is
// accepted every cycle and the window state feeds back combinationally.
// When the receiver stalls, the result register holds and the input
// register still takes one more symbol before sym_in.ready drops.
// Reset clears both valid flags and the windows and sets the length to 31.
// ----------------------------------------------------------------------------
`default_nettype none

`include "canonical_kmer_roller_defines.svh"

module canonical_kmer_roller
#(
    parameter int MAX_K = kmr_pkg::MAX_K_DEF
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [kmr_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [kmr_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [kmr_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                    pready,
    kmr_sym_if.sink                                 sym_in,
    kmr_res_if.source                               res_out
);

    kmr_pkg::kmr_cfg_t         cfg;
    kmr_pkg::kmr_result_t      result;
    kmr_pkg::kmr_result_t      out_res_reg;

    logic                      s1_valid_reg;
    logic                      s1_valid_next;
    logic [kmr_pkg::SYM_W-1:0] s1_sym_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      out_free;
    logic                      advance;
    logic                      in_take;

    kmr_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    kmr_window #(.MAX_K(MAX_K)) u_window
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (advance),
        .symbol (s1_sym_reg),
        .result (result)
    );

    assign out_free     = !out_valid_reg || res_out.ready;
    assign advance      = s1_valid_reg && out_free;
    assign sym_in.ready = !s1_valid_reg || advance;
    assign in_take      = sym_in.valid && sym_in.ready;

    always_comb
    begin
        s1_valid_next  = in_take ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
        out_valid_next = advance ? 1'b1 : (res_out.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_sym_reg <= sym_in.symbol;
        end
        if (advance)
        begin
            out_res_reg <= result;
        end
    end

    assign res_out.valid              = out_valid_reg;
    assign res_out.kmer_ready         = out_res_reg.kmer_ready;
    assign res_out.fwd_canonical      = out_res_reg.fwd_canonical;
    assign res_out.prev_fwd_canonical = out_res_reg.prev_fwd_canonical;
    assign res_out.prev_kmer_existed  = out_res_reg.prev_kmer_existed;
    assign res_out.fill_count         = out_res_reg.fill_count;
    assign res_out.pushed_off         = out_res_reg.pushed_off;
    assign res_out.canon_high         = out_res_reg.canon_high;
    assign res_out.canon_low          = out_res_reg.canon_low;
    assign res_out.bad_symbol         = out_res_reg.bad_symbol;

    `KMR_ASSERT_IMPLY(a_full_stays_ready, res_out.valid && res_out.prev_kmer_existed, res_out.kmer_ready, "window reported as full before but not ready now")
    `KMR_ASSERT_IMPLY(a_bad_clears, res_out.valid && res_out.bad_symbol, res_out.fill_count == '0 && res_out.fwd_canonical && !res_out.kmer_ready, "bad symbol result not in reset form")
    `KMR_ASSERT(a_no_overrun, !(s1_valid_reg && !out_free && sym_in.ready), "input register overwritten while result stalled")

endmodule

`default_nettype wire

/* hdl/kmr_cfg.sv */
// ----------------------------------------------------------------------------
// Canonical k-mer roller configuration
// APB register file holding the k-mer length; a write also clears the windows.
// ----------------------------------------------------------------------------
`default_nettype none

module kmr_cfg
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [kmr_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [kmr_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [kmr_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                    pready,
    output kmr_pkg::kmr_cfg_t                       cfg
);

    logic [kmr_pkg::LEN_W-1:0] kmer_len_reg;
    logic [kmr_pkg::LEN_W-1:0] kmer_len_next;
    logic                      len_sel;
    logic                      len_write;

    assign len_sel   = (paddr[kmr_pkg::APB_ADDR_W-1] == kmr_pkg::KMER_LEN_IDX);
    assign len_write = psel && penable && pwrite && len_sel;
    assign pready    = 1'b1;

    always_comb
    begin
        kmer_len_next = kmer_len_reg;
        if (len_write)
        begin
            kmer_len_next = pwdata[kmr_pkg::LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_len_reg <= kmr_pkg::KMER_LEN_RST;
        end
        else
        begin
            kmer_len_reg <= kmer_len_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (len_sel)
        begin
            prdata = kmr_pkg::APB_DATA_W'(kmer_len_reg);
        end
    end

    assign cfg.kmer_len = kmer_len_reg;
    assign cfg.clear    = len_write;

endmodule

`default_nettype wire

/* hdl/kmr_window.sv */
// ----------------------------------------------------------------------------
// Canonical k-mer window
// Forward and reverse-complement windows with the one-step update and compare.
// ----------------------------------------------------------------------------
`default_nettype none

module kmr_window
#(
    parameter int MAX_K = kmr_pkg::MAX_K_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire kmr_pkg::kmr_cfg_t             cfg,
    input  wire logic                          step,
    input  wire logic [kmr_pkg::SYM_W-1:0]     symbol,
    output kmr_pkg::kmr_result_t               result
);

    localparam int LimK    = (MAX_K < kmr_pkg::WORD_W) ? MAX_K : kmr_pkg::WORD_W;
    localparam int WinW    = 2 * LimK;
    localparam int CntW    = $clog2(LimK + 1);
    localparam int BitsW   = CntW + 1;
    localparam int CanonW  = 2 * kmr_pkg::WORD_W;

    logic [WinW-1:0]   fw_reg;
    logic [WinW-1:0]   fw_next;
    logic [WinW-1:0]   rc_reg;
    logic [WinW-1:0]   rc_next;
    logic [CntW-1:0]   count_reg;
    logic [CntW-1:0]   count_next;
    logic              canon_reg;
    logic              canon_next;
    logic              prev_canon_reg;
    logic              prev_full_reg;
    logic              prev_full_next;

    logic [kmr_pkg::LEN_W-1:0] k_eff;
    logic [CntW-1:0]   k;
    logic [BitsW-1:0]  bits;
    logic [BitsW-1:0]  top_pos;
    logic [BitsW-1:0]  fill_pos;
    logic [WinW-1:0]   mask;
    logic [1:0]        sym;
    logic [1:0]        comp;
    logic [1:0]        pushed;
    logic              bad;
    logic              was_full;
    logic [CanonW-1:0] canon_wide;

    assign k_eff    = kmr_pkg::kmr_eff_len(cfg.kmer_len, kmr_pkg::LEN_W'(LimK));
    assign k        = CntW'(k_eff);
    assign bits     = {k, 1'b0};
    assign top_pos  = bits - BitsW'(2);
    assign fill_pos = {count_reg, 1'b0};
    assign mask     = {WinW{1'b1}} >> (BitsW'(WinW) - bits);

    assign bad      = symbol[kmr_pkg::SYM_W-1];
    assign sym      = symbol[1:0];
    assign comp     = 2'd3 - sym;
    assign was_full = (count_reg == k);
    assign pushed   = 2'(fw_reg >> top_pos);

    always_comb
    begin
        fw_next = ((fw_reg << 2) | WinW'(sym)) & mask;
        if (was_full)
        begin
            rc_next = (rc_reg >> 2) | (WinW'(comp) << top_pos);
        end
        else
        begin
            rc_next = rc_reg | (WinW'(comp) << fill_pos);
        end
        canon_next     = (fw_next <= rc_next);
        count_next     = was_full ? count_reg : count_reg + CntW'(1);
        prev_full_next = prev_full_reg | was_full;
        canon_wide     = canon_next ? CanonW'(fw_next) : CanonW'(rc_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg         <= '0;
            rc_reg         <= '0;
            count_reg      <= '0;
            canon_reg      <= 1'b1;
            prev_canon_reg <= 1'b1;
            prev_full_reg  <= 1'b0;
        end
        else if (cfg.clear || (step && bad))
        begin
            fw_reg         <= '0;
            rc_reg         <= '0;
            count_reg      <= '0;
            canon_reg      <= 1'b1;
            prev_canon_reg <= 1'b1;
            prev_full_reg  <= 1'b0;
        end
        else if (step)
        begin
            fw_reg         <= fw_next;
            rc_reg         <= rc_next;
            count_reg      <= count_next;
            canon_reg      <= canon_next;
            prev_canon_reg <= canon_reg;
            prev_full_reg  <= prev_full_next;
        end
    end

    always_comb
    begin
        if (bad)
        begin
            result.kmer_ready         = 1'b0;
            result.fwd_canonical      = 1'b1;
            result.prev_fwd_canonical = 1'b1;
            result.prev_kmer_existed  = 1'b0;
            result.fill_count         = '0;
            result.pushed_off         = '0;
            result.canon_high         = '0;
            result.canon_low          = '0;
            result.bad_symbol         = 1'b1;
        end
        else
        begin
            result.kmer_ready         = (count_next == k);
            result.fwd_canonical      = canon_next;
            result.prev_fwd_canonical = canon_reg;
            result.prev_kmer_existed  = prev_full_next;
            result.fill_count         = kmr_pkg::LEN_W'(count_next);
            result.pushed_off         = pushed;
            result.canon_high         = canon_wide[CanonW-1:kmr_pkg::WORD_W];
            result.canon_low          = canon_wide[kmr_pkg::WORD_W-1:0];
            result.bad_symbol         = 1'b0;
        end
    end

endmodule

`default_nettype wire

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// Canonical k-mer roller testbench
// Drives nucleotide codes into the roller. A model inside the bench tracks
// the forward and reverse-complement windows and predicts every result beat.
// Directed tests cover the length extremes, invalid codes and register
// decoding. Random phases vary the length and the idling on both channels.
// A long receiver hold-off backs the roller up until it stalls its input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [kmr_pkg::APB_ADDR_W-1:0] LEN_ADDR    = {kmr_pkg::KMER_LEN_IDX, 2'b00};
    localparam logic [kmr_pkg::APB_ADDR_W-1:0] UNUSED_ADDR = 3'd4;
    localparam int                             MAX_PRINTS  = 100;

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [kmr_pkg::APB_ADDR_W-1:0] paddr;
    logic [kmr_pkg::APB_DATA_W-1:0] pwdata;
    logic [kmr_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    kmr_sym_if sym ();
    kmr_res_if res ();

    canonical_kmer_roller u_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .sym_in  (sym),
        .res_out (res)
    );

    // Predicted roller state.
    logic [kmr_pkg::LEN_W-1:0] len_reg;
    logic [127:0]     fwd_kmer;
    logic [127:0]     rc_kmer;
    int               fill;
    bit               canon_now;
    bit               canon_before;
    bit               seen_full;

    kmr_pkg::kmr_result_t expected_kmers[$];
    int          mismatches;
    int          sender_idle_pct;
    int          stall_pct;
    int          hold_left;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic void clear_windows();
        fwd_kmer     = '0;
        rc_kmer      = '0;
        fill         = 0;
        canon_now    = 1'b1;
        canon_before = 1'b1;
        seen_full    = 1'b0;
    endfunction

    function automatic int effective_len();
        int k;
        k = int'(len_reg);
        if (k < 1)
        begin
            k = 1;
        end
        if (k > 64)
        begin
            k = 64;
        end
        return k;
    endfunction

    // Advances the model by one code and returns the beat it predicts.
    function automatic kmr_pkg::kmr_result_t roll_kmer(input logic [kmr_pkg::SYM_W-1:0] s);
        kmr_pkg::kmr_result_t r;
        int          k;
        int          nbits;
        logic [127:0] mask;
        logic [127:0] canon;
        logic [1:0]  comp;
        logic [1:0]  leaving;
        bit          was_full;
        k     = effective_len();
        nbits = 2 * k;
        mask  = (128'd1 << nbits) - 128'd1;
        r     = '0;
        if (s > 3)
        begin
            clear_windows();
            r.fwd_canonical      = 1'b1;
            r.prev_fwd_canonical = 1'b1;
            r.bad_symbol         = 1'b1;
            return r;
        end
        leaving  = fwd_kmer[nbits-2 +: 2];
        comp     = 2'd3 - s[1:0];
        was_full = (fill == k);
        fwd_kmer = ((fwd_kmer << 2) | 128'(s[1:0])) & mask;
        if (was_full)
        begin
            rc_kmer = (rc_kmer >> 2) | (128'(comp) << (nbits - 2));
        end
        else
        begin
            rc_kmer = rc_kmer | (128'(comp) << (2 * fill));
        end
        canon_before = canon_now;
        canon_now    = (fwd_kmer <= rc_kmer);
        if (was_full)
        begin
            seen_full = 1'b1;
        end
        if (fill < k)
        begin
            fill++;
        end
        canon                = canon_now ? fwd_kmer : rc_kmer;
        r.kmer_ready         = (fill == k);
        r.fwd_canonical      = canon_now;
        r.prev_fwd_canonical = canon_before;
        r.prev_kmer_existed  = seen_full;
        r.fill_count         = kmr_pkg::LEN_W'(fill);
        r.pushed_off         = leaving;
        r.canon_high         = canon[127:64];
        r.canon_low          = canon[63:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTS)
        begin
            $display("tb: mismatch at %0t: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    // Compares every accepted result beat with the oldest prediction.
    always @(posedge clk)
    begin
        kmr_pkg::kmr_result_t want;
        if (rst_n && res.valid && res.ready)
        begin
            if (expected_kmers.size() == 0)
            begin
                report_mismatch("result beat with nothing expected");
            end
            else
            begin
                want = expected_kmers.pop_front();
                check_field("kmer_ready", 64'(res.kmer_ready), 64'(want.kmer_ready));
                check_field("fwd_canonical", 64'(res.fwd_canonical),
                            64'(want.fwd_canonical));
                check_field("prev_fwd_canonical", 64'(res.prev_fwd_canonical),
                            64'(want.prev_fwd_canonical));
                check_field("prev_kmer_existed", 64'(res.prev_kmer_existed),
                            64'(want.prev_kmer_existed));
                check_field("fill_count", 64'(res.fill_count), 64'(want.fill_count));
                check_field("pushed_off", 64'(res.pushed_off), 64'(want.pushed_off));
                check_field("canon_high", res.canon_high, want.canon_high);
                check_field("canon_low", res.canon_low, want.canon_low);
                check_field("bad_symbol", 64'(res.bad_symbol), 64'(want.bad_symbol));
            end
        end
    end

    // Receiver: random stalls, or a counted hold-off when one is requested.
    initial
    begin
        res.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                res.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                res.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_symbol(input logic [kmr_pkg::SYM_W-1:0] s);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            sym.valid <= 1'b0;
            @(posedge clk);
        end
        sym.valid  <= 1'b1;
        sym.symbol <= s;
        do
        begin
            @(posedge clk);
        end
        while (!sym.ready);
        expected_kmers.push_back(roll_kmer(s));
    endtask

    task automatic drain();
        sym.valid <= 1'b0;
        @(posedge clk);
        while (expected_kmers.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic [kmr_pkg::APB_ADDR_W-1:0] addr,
                             input logic [kmr_pkg::APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == LEN_ADDR)
        begin
            len_reg = data[kmr_pkg::LEN_W-1:0];
            clear_windows();
        end
    endtask

    task automatic check_length_readback();
        logic [kmr_pkg::APB_DATA_W-1:0] data;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= LEN_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        check_field("kmer_len readback", 64'(data[kmr_pkg::LEN_W-1:0]), 64'(len_reg));
    endtask

    task automatic set_length(input logic [kmr_pkg::LEN_W-1:0] len);
        logic [kmr_pkg::APB_DATA_W-1:0] data;
        drain();
        data           = $urandom();
        data[kmr_pkg::LEN_W-1:0] = len;
        apb_write(LEN_ADDR, data);
        @(posedge clk);
        check_length_readback();
    endtask

    task automatic send_list(input logic [kmr_pkg::SYM_W-1:0] list[$]);
        foreach (list[i])
        begin
            send_symbol(list[i]);
        end
    endtask

    task automatic test_default_length();
        send_list('{3'd3, 3'd0, 3'd7, 3'd2});
    endtask

    task automatic test_length_extremes();
        set_length(7'd0);
        send_list('{3'd0, 3'd3, 3'd1, 3'd2});
        set_length(7'd2);
        send_list('{3'd0, 3'd3, 3'd3, 3'd0, 3'd4, 3'd1});
        set_length(7'd127);
        send_list('{3'd3, 3'd2, 3'd1, 3'd0, 3'd5, 3'd6});
    endtask

    task automatic test_unknown_register();
        drain();
        apb_write(UNUSED_ADDR, 32'h0000_0005);
        send_list('{3'd1, 3'd2, 3'd3});
    endtask

    function automatic logic [kmr_pkg::LEN_W-1:0] pick_length();
        logic [kmr_pkg::LEN_W-1:0] len;
        int               sel;
        sel = $urandom_range(9);
        if (sel < 5)
        begin
            len = kmr_pkg::LEN_W'($urandom_range(1, 8));
        end
        else if (sel < 7)
        begin
            len = kmr_pkg::LEN_W'($urandom_range(9, 63));
        end
        else if (sel == 7)
        begin
            len = 7'd64;
        end
        else if (sel == 8)
        begin
            len = kmr_pkg::LEN_W'($urandom_range(65, 127));
        end
        else
        begin
            len = 7'd0;
        end
        return len;
    endfunction

    function automatic logic [kmr_pkg::SYM_W-1:0] pick_symbol();
        if ($urandom_range(99) < 3)
        begin
            return kmr_pkg::SYM_W'($urandom_range(4, 7));
        end
        return kmr_pkg::SYM_W'($urandom_range(0, 3));
    endfunction

    task automatic random_phase(input int idle, input int stall, input int budget);
        int left;
        int run;
        sender_idle_pct = idle;
        stall_pct       = stall;
        left            = budget;
        while (left > 0)
        begin
            set_length(pick_length());
            run = 2 * effective_len() + $urandom_range(4, 24);
            if (run > left)
            begin
                run = left;
            end
            repeat (run) send_symbol(pick_symbol());
            left -= run;
        end
    endtask

    task automatic test_random_phases();
        random_phase(0, 0, 310);
        random_phase(79, 0, 300);
        random_phase(0, 79, 300);
        random_phase(34, 34, 300);
    endtask

    // The receiver holds off long enough for the roller to fill and stall
    // its input while beats keep being offered.
    task automatic test_backpressure();
        set_length(7'd5);
        sender_idle_pct = 0;
        stall_pct       = 0;
        hold_left       = 300;
        repeat (40) send_symbol(pick_symbol());
    endtask

    initial
    begin
        rst_n           = 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        sym.valid      <= 1'b0;
        sym.symbol     <= '0;
        mismatches      = 0;
        sender_idle_pct = 0;
        stall_pct       = 0;
        hold_left       = 0;
        len_reg         = kmr_pkg::KMER_LEN_RST;
        clear_windows();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_length();
        test_length_extremes();
        test_unknown_register();
        test_backpressure();
        test_random_phases();

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
